// File: rtl/core/tlrd_pkg.sv
// ----------------------------------------------------------------------------
// tlrd_pkg
// Shared types and constants of the thin-lens ray direction pipeline.
// ----------------------------------------------------------------------------
package tlrd_pkg;

    // field and datapath widths
    localparam int Q16_W      = 32;
    localparam int DIR_W      = 16;
    localparam int COMP_W     = 16;
    localparam int BASIS_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = 64;
    localparam int PU_W       = 48;
    localparam int PW_W       = 49;
    localparam int C_W        = 50;
    localparam int MAG_W      = 49;
    localparam int NORM_PAD   = 29;
    localparam int NORM_W     = MAG_W + NORM_PAD;
    localparam int M_W        = 30;
    localparam int SQ_W       = 2 * M_W;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQREM_W    = 32;
    localparam int DIV_W      = 32;
    localparam int QUO_W      = 16;
    localparam int DIR_FRAC   = 14;
    localparam int NUM_W      = M_W + DIR_FRAC + 1;

    // cell counts of the chains
    localparam int FDIV_N  = Q16_W;
    localparam int NORM_N  = 7;
    localparam int SQRT_N  = ROOT_W;
    localparam int QDIV_N  = QUO_W;

    // fixed values
    localparam logic [QUO_W-1:0]        DIR_ONE   = 16'd16384;
    localparam logic signed [Q16_W-1:0] Q16_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [Q16_W-1:0] Q16_MIN   = 32'sh8000_0000;
    localparam logic [Q16_W-1:0]        NEG_LIMIT = 32'h8000_0000;

    // register reset values
    localparam logic [Q16_W-1:0]   FOCAL_RESET   = 32'h0001_0000;
    localparam logic [Q16_W-1:0]   VIEW_RESET    = 32'h0001_0000;
    localparam logic [BASIS_W-1:0] BASIS_U_RESET = 48'h0000_0000_4000;
    localparam logic [BASIS_W-1:0] BASIS_V_RESET = 48'h0000_4000_0000;
    localparam logic [BASIS_W-1:0] BASIS_W_RESET = 48'h4000_0000_0000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_DIST = 3'd0,
        REG_VIEW_DIST  = 3'd1,
        REG_BASIS_U    = 3'd2,
        REG_BASIS_V    = 3'd3,
        REG_BASIS_W    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [Q16_W-1:0] pixel_x;
        logic signed [Q16_W-1:0] pixel_y;
        logic signed [Q16_W-1:0] lens_x;
        logic signed [Q16_W-1:0] lens_y;
    } in_item_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    zero_length;
        logic                    saturated;
    } out_item_t;

    // side data riding along the focal divide chain
    typedef struct packed {
        logic signed [1:0][Q16_W-1:0] lens;
        logic [1:0]                   neg;
        logic [1:0]                   zero;
        logic [1:0]                   ovf;
    } fs_side_t;

    // per-item flags through normalize and final divide
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        logic       sat;
    } flag_side_t;

    // side data riding along the square root chain
    typedef struct packed {
        logic [2:0][M_W-1:0] mag;
        flag_side_t          flags;
    } sq_side_t;

endpackage

// File: rtl/core/thin_lens_ray_direction.sv
// ----------------------------------------------------------------------------
// thin_lens_ray_direction
// Thin-lens camera ray direction: takes one pixel/lens sample beat per clock
// while the output side does not stall and returns one unit direction beat
// for each, in order. The work runs down a row of cells: a 32-cell
// divider for the focal scaling, three multiply and add stages for the basis
// combination, a 7-cell shifter for normalization, a 31-cell square root and
// a 16-cell divider for the unit scaling. Each cell holds one beat and passes
// it on every cycle, so throughput is one beat per clock; a stalled output
// backs the row up one cell at a time and the input keeps taking beats until
// every cell is full. Configuration writes take effect at once and must be
// made while no beat is in flight.
// ----------------------------------------------------------------------------
module thin_lens_ray_direction
    import tlrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [Q16_W-1:0]   focal_reg;
    logic [Q16_W-1:0]   view_reg;
    logic [BASIS_W-1:0] basis_u_reg;
    logic [BASIS_W-1:0] basis_v_reg;
    logic [BASIS_W-1:0] basis_w_reg;

    assign cfg_ready = 1'b1;

    // register write decode, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg   <= FOCAL_RESET;
            view_reg    <= VIEW_RESET;
            basis_u_reg <= BASIS_U_RESET;
            basis_v_reg <= BASIS_V_RESET;
            basis_w_reg <= BASIS_W_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FOCAL_DIST: focal_reg   <= cfg_data[Q16_W-1:0];
                REG_VIEW_DIST:  view_reg    <= cfg_data[Q16_W-1:0];
                REG_BASIS_U:    basis_u_reg <= cfg_data;
                REG_BASIS_V:    basis_v_reg <= cfg_data;
                REG_BASIS_W:    basis_w_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage a: pixel magnitude times focal distance
    // ------------------------------------------------------------------
    logic                         a_valid_reg;
    logic                         a_ready;
    logic [1:0][PROD_W-1:0]       a_prod_reg, a_prod_next;
    logic [1:0]                   a_neg_reg, a_neg_next;
    logic [1:0]                   a_zero_reg, a_zero_next;
    logic signed [1:0][Q16_W-1:0] a_lens_reg;

    always_comb
    begin
        logic [1:0][Q16_W-1:0] pix;
        logic [Q16_W-1:0]      mag;
        pix[0] = in_data.pixel_x;
        pix[1] = in_data.pixel_y;
        for (int l = 0; l < 2; l++)
        begin
            a_neg_next[l]  = pix[l][Q16_W-1];
            mag            = a_neg_next[l] ? Q16_W'(-pix[l]) : pix[l];
            a_zero_next[l] = (mag == '0);
            a_prod_next[l] = PROD_W'(mag) * PROD_W'(focal_reg);
        end
    end

    logic fd_v [0:FDIV_N];
    logic fd_r [0:FDIV_N];

    assign a_ready  = !a_valid_reg || fd_r[0];
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_prod_reg    <= a_prod_next;
            a_neg_reg     <= a_neg_next;
            a_zero_reg    <= a_zero_next;
            a_lens_reg[0] <= in_data.lens_x;
            a_lens_reg[1] <= in_data.lens_y;
        end
    end

    // ------------------------------------------------------------------
    // focal divide chain: product over view distance, one bit per cell
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]        fd_div  [0:FDIV_N];
    logic [1:0][DIV_W-1:0]   fd_rem  [0:FDIV_N];
    logic [1:0][Q16_W-1:0]   fd_num  [0:FDIV_N];
    fs_side_t                fd_side [0:FDIV_N];

    // quotient overflows 32 bits when the high half is not below the divisor
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            fd_rem[0][l]      = a_prod_reg[l][PROD_W-1 -: Q16_W];
            fd_num[0][l]      = a_prod_reg[l][Q16_W-1:0];
            fd_side[0].ovf[l] = (a_prod_reg[l][PROD_W-1 -: Q16_W] >= view_reg);
        end
        fd_side[0].lens = a_lens_reg;
        fd_side[0].neg  = a_neg_reg;
        fd_side[0].zero = a_zero_reg;
    end

    assign fd_v[0]   = a_valid_reg;
    assign fd_div[0] = view_reg;

    for (genvar i = 0; i < FDIV_N; i++)
    begin : g_fdiv
        tlrd_div_cell #(
            .LANES (2),
            .W     (DIV_W),
            .NW    (Q16_W),
            .SW    ($bits(fs_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (fd_v[i]),
            .in_ready  (fd_r[i]),
            .in_div    (fd_div[i]),
            .in_rem    (fd_rem[i]),
            .in_num    (fd_num[i]),
            .in_side   (fd_side[i]),
            .out_valid (fd_v[i+1]),
            .out_ready (fd_r[i+1]),
            .out_div   (fd_div[i+1]),
            .out_rem   (fd_rem[i+1]),
            .out_num   (fd_num[i+1]),
            .out_side  (fd_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage b: signed focal point, minus lens point, saturated
    // ------------------------------------------------------------------
    logic                         b_valid_reg;
    logic                         b_ready;
    logic signed [1:0][Q16_W-1:0] b_d_reg, b_d_next;
    logic                         b_sat_reg, b_sat_next;
    logic                         c_ready;

    always_comb
    begin
        logic [Q16_W-1:0]        q;
        logic signed [Q16_W:0]   p;
        logic signed [Q16_W+1:0] diff;
        fs_side_t                sd;
        sd         = fd_side[FDIV_N];
        b_sat_next = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            q = fd_num[FDIV_N][l];
            if (sd.zero[l])
                p = '0;
            else if (sd.neg[l])
            begin
                if (sd.ovf[l] || (q > NEG_LIMIT))
                begin
                    p          = (Q16_W + 1)'(Q16_MIN);
                    b_sat_next = 1'b1;
                end
                else
                    p = -$signed({1'b0, q});
            end
            else
            begin
                if (sd.ovf[l] || q[Q16_W-1])
                begin
                    p          = (Q16_W + 1)'(Q16_MAX);
                    b_sat_next = 1'b1;
                end
                else
                    p = $signed({1'b0, q});
            end
            diff = (Q16_W + 2)'(p) - (Q16_W + 2)'($signed(sd.lens[l]));
            if (diff > (Q16_W + 2)'(Q16_MAX))
            begin
                b_d_next[l] = Q16_MAX;
                b_sat_next  = 1'b1;
            end
            else if (diff < (Q16_W + 2)'(Q16_MIN))
            begin
                b_d_next[l] = Q16_MIN;
                b_sat_next  = 1'b1;
            end
            else
                b_d_next[l] = diff[Q16_W-1:0];
        end
    end

    assign b_ready        = !b_valid_reg || c_ready;
    assign fd_r[FDIV_N]   = b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= fd_v[FDIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_d_reg   <= b_d_next;
            b_sat_reg <= b_sat_next;
        end
    end

    // ------------------------------------------------------------------
    // stage c: basis products
    // ------------------------------------------------------------------
    logic                      c_valid_reg;
    logic signed [PU_W-1:0]    c_pu_reg [0:2];
    logic signed [PU_W-1:0]    c_pv_reg [0:2];
    logic signed [PW_W-1:0]    c_pw_reg [0:2];
    logic signed [PU_W-1:0]    c_pu_next [0:2];
    logic signed [PU_W-1:0]    c_pv_next [0:2];
    logic signed [PW_W-1:0]    c_pw_next [0:2];
    logic                      c_sat_reg;
    logic                      d_ready;

    always_comb
    begin
        logic signed [Q16_W-1:0]  dx;
        logic signed [Q16_W-1:0]  dy;
        logic signed [Q16_W:0]    fd;
        logic signed [COMP_W-1:0] uk;
        logic signed [COMP_W-1:0] vk;
        logic signed [COMP_W-1:0] wk;
        dx = b_d_reg[0];
        dy = b_d_reg[1];
        fd = $signed({1'b0, focal_reg});
        for (int k = 0; k < 3; k++)
        begin
            uk           = basis_u_reg[COMP_W*k +: COMP_W];
            vk           = basis_v_reg[COMP_W*k +: COMP_W];
            wk           = basis_w_reg[COMP_W*k +: COMP_W];
            c_pu_next[k] = PU_W'(dx) * PU_W'(uk);
            c_pv_next[k] = PU_W'(dy) * PU_W'(vk);
            c_pw_next[k] = PW_W'(fd) * PW_W'(wk);
        end
    end

    assign c_ready = !c_valid_reg || d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_pu_reg  <= c_pu_next;
            c_pv_reg  <= c_pv_next;
            c_pw_reg  <= c_pw_next;
            c_sat_reg <= b_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage d: component sums, exact
    // ------------------------------------------------------------------
    logic                   d_valid_reg;
    logic signed [C_W-1:0]  d_c_reg  [0:2];
    logic signed [C_W-1:0]  d_c_next [0:2];
    logic                   d_sat_reg;

    logic                                nm_v    [0:NORM_N];
    logic                                nm_r    [0:NORM_N];
    logic [3:0][NORM_W-1:0]              nm_lane [0:NORM_N];
    flag_side_t                          nm_side [0:NORM_N];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            d_c_next[k] = C_W'(c_pu_reg[k]) + C_W'(c_pv_reg[k]) - C_W'(c_pw_reg[k]);
    end

    assign d_ready = !d_valid_reg || nm_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (d_ready)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            d_c_reg   <= d_c_next;
            d_sat_reg <= c_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // normalize chain: magnitudes padded below, or-word in lane 0
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [C_W-1:0]    cm;
        logic [NORM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            cm                    = d_c_reg[k][C_W-1] ? C_W'(-d_c_reg[k]) : d_c_reg[k];
            nm_lane[0][k+1]       = {cm[MAG_W-1:0], {NORM_PAD{1'b0}}};
            acc                   = acc | nm_lane[0][k+1];
            nm_side[0].neg[k]     = d_c_reg[k][C_W-1];
        end
        nm_lane[0][0]   = acc;
        nm_side[0].zero = (acc == '0);
        nm_side[0].sat  = d_sat_reg;
    end

    assign nm_v[0] = d_valid_reg;

    for (genvar i = 0; i < NORM_N; i++)
    begin : g_norm
        tlrd_norm_cell #(
            .LANES (4),
            .W     (NORM_W),
            .SH    (1 << (NORM_N - 1 - i)),
            .SW    ($bits(flag_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (nm_v[i]),
            .in_ready  (nm_r[i]),
            .in_lane   (nm_lane[i]),
            .in_side   (nm_side[i]),
            .out_valid (nm_v[i+1]),
            .out_ready (nm_r[i+1]),
            .out_lane  (nm_lane[i+1]),
            .out_side  (nm_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage f: squares of the normalized magnitudes
    // ------------------------------------------------------------------
    logic                 f_valid_reg;
    logic                 f_ready;
    logic [SQ_W-1:0]      f_sq_reg  [0:2];
    logic [SQ_W-1:0]      f_sq_next [0:2];
    sq_side_t             f_side_reg, f_side_next;

    logic                 sq_v    [0:SQRT_N];
    logic                 sq_r    [0:SQRT_N];
    logic [SQREM_W-1:0]   sq_rem  [0:SQRT_N];
    logic [ROOT_W-1:0]    sq_root [0:SQRT_N];
    logic [SUM_W-1:0]     sq_rad  [0:SQRT_N];
    sq_side_t             sq_side [0:SQRT_N];

    always_comb
    begin
        logic [M_W-1:0] m;
        for (int k = 0; k < 3; k++)
        begin
            m                    = nm_lane[NORM_N][k+1][NORM_W-1 -: M_W];
            f_side_next.mag[k]   = m;
            f_sq_next[k]         = SQ_W'(m) * SQ_W'(m);
        end
        f_side_next.flags = nm_side[NORM_N];
    end

    assign f_ready        = !f_valid_reg || sq_r[0];
    assign nm_r[NORM_N]   = f_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (f_ready)
            f_valid_reg <= nm_v[NORM_N];
    end

    always_ff @(posedge clk)
    begin
        if (f_ready)
        begin
            f_sq_reg   <= f_sq_next;
            f_side_reg <= f_side_next;
        end
    end

    // ------------------------------------------------------------------
    // square root chain on the sum of squares
    // ------------------------------------------------------------------
    assign sq_v[0]    = f_valid_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = SUM_W'(f_sq_reg[0]) + SUM_W'(f_sq_reg[1]) + SUM_W'(f_sq_reg[2]);
    assign sq_side[0] = f_side_reg;

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqrt
        tlrd_sqrt_cell #(
            .SW ($bits(sq_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_ready  (sq_r[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_rad    (sq_rad[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_ready (sq_r[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // unit divide chain: rounded magnitude * 2^14 over length
    // ------------------------------------------------------------------
    logic                   qd_v    [0:QDIV_N];
    logic                   qd_r    [0:QDIV_N];
    logic [DIV_W-1:0]       qd_div  [0:QDIV_N];
    logic [2:0][DIV_W-1:0]  qd_rem  [0:QDIV_N];
    logic [2:0][QUO_W-1:0]  qd_num  [0:QDIV_N];
    flag_side_t             qd_side [0:QDIV_N];

    always_comb
    begin
        logic [NUM_W-1:0]  num;
        logic [ROOT_W-1:0] len;
        len = sq_root[SQRT_N];
        for (int k = 0; k < 3; k++)
        begin
            num          = NUM_W'({sq_side[SQRT_N].mag[k], {DIR_FRAC{1'b0}}})
                         + NUM_W'(len[ROOT_W-1:1]);
            qd_rem[0][k] = DIV_W'(num[NUM_W-1:QUO_W]);
            qd_num[0][k] = num[QUO_W-1:0];
        end
        qd_div[0] = DIV_W'(len);
    end

    assign qd_v[0]        = sq_v[SQRT_N];
    assign sq_r[SQRT_N]   = qd_r[0];
    assign qd_side[0]     = sq_side[SQRT_N].flags;

    for (genvar i = 0; i < QDIV_N; i++)
    begin : g_qdiv
        tlrd_div_cell #(
            .LANES (3),
            .W     (DIV_W),
            .NW    (QUO_W),
            .SW    ($bits(flag_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (qd_v[i]),
            .in_ready  (qd_r[i]),
            .in_div    (qd_div[i]),
            .in_rem    (qd_rem[i]),
            .in_num    (qd_num[i]),
            .in_side   (qd_side[i]),
            .out_valid (qd_v[i+1]),
            .out_ready (qd_r[i+1]),
            .out_div   (qd_div[i+1]),
            .out_rem   (qd_rem[i+1]),
            .out_num   (qd_num[i+1]),
            .out_side  (qd_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: clamp, sign, zero-length override
    // ------------------------------------------------------------------
    logic      out_valid_reg;
    logic      o_ready;
    out_item_t out_data_reg, out_data_next;

    always_comb
    begin
        logic [2:0][DIR_W-1:0] dir;
        logic [QUO_W-1:0]      q;
        flag_side_t            fl;
        fl = qd_side[QDIV_N];
        for (int k = 0; k < 3; k++)
        begin
            q = qd_num[QDIV_N][k];
            if (q > DIR_ONE)
                q = DIR_ONE;
            if (fl.zero)
                dir[k] = '0;
            else if (fl.neg[k])
                dir[k] = DIR_W'(-q);
            else
                dir[k] = q;
        end
        out_data_next.dir_x       = dir[0];
        out_data_next.dir_y       = dir[1];
        out_data_next.dir_z       = dir[2];
        out_data_next.zero_length = fl.zero;
        out_data_next.saturated   = fl.sat;
    end

    assign o_ready        = !out_valid_reg || out_ready;
    assign qd_r[QDIV_N]   = o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (o_ready)
            out_valid_reg <= qd_v[QDIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (o_ready)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a zero-length beat carries a zero direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_length |->
            (out_data.dir_x == '0) && (out_data.dir_y == '0) && (out_data.dir_z == '0))
    else $error("zero-length beat with nonzero direction");

    // direction components stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ($signed(out_data.dir_x) <= $signed(DIR_W'(DIR_ONE))) &&
            ($signed(out_data.dir_x) >= -$signed(DIR_W'(DIR_ONE))) &&
            ($signed(out_data.dir_y) <= $signed(DIR_W'(DIR_ONE))) &&
            ($signed(out_data.dir_y) >= -$signed(DIR_W'(DIR_ONE))) &&
            ($signed(out_data.dir_z) <= $signed(DIR_W'(DIR_ONE))) &&
            ($signed(out_data.dir_z) >= -$signed(DIR_W'(DIR_ONE))))
    else $error("direction component out of unit range");

    // input only backs up when the whole row is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline has room");

endmodule

// File: rtl/core/tlrd_div_cell.sv
// ----------------------------------------------------------------------------
// tlrd_div_cell
// One restoring divide step per cell over several lanes sharing a divisor.
// ----------------------------------------------------------------------------
module tlrd_div_cell
    import tlrd_pkg::*;
#(
    parameter int LANES = 2,
    parameter int W     = 32,
    parameter int NW    = 32,
    parameter int SW    = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [W-1:0]               in_div,
    input  logic [LANES-1:0][W-1:0]    in_rem,
    input  logic [LANES-1:0][NW-1:0]   in_num,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [W-1:0]               out_div,
    output logic [LANES-1:0][W-1:0]    out_rem,
    output logic [LANES-1:0][NW-1:0]   out_num,
    output logic [SW-1:0]              out_side
);

    logic                     valid_reg;
    logic [W-1:0]             div_reg;
    logic [LANES-1:0][W-1:0]  rem_reg, rem_next;
    logic [LANES-1:0][NW-1:0] num_reg, num_next;
    logic [SW-1:0]            side_reg;

    // bring down one numerator bit, subtract when it fits
    always_comb
    begin
        logic [W:0] t;
        logic       ge;
        for (int l = 0; l < LANES; l++)
        begin
            t           = {in_rem[l], in_num[l][NW-1]};
            ge          = (t >= {1'b0, in_div});
            rem_next[l] = ge ? W'(t - {1'b0, in_div}) : t[W-1:0];
            num_next[l] = {in_num[l][NW-2:0], ge};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // beat occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            div_reg  <= in_div;
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/core/tlrd_norm_cell.sv
// ----------------------------------------------------------------------------
// tlrd_norm_cell
// One binary normalize step: shifts all lanes left by SH when the top SH
// bits of the control lane (lane 0) are clear.
// ----------------------------------------------------------------------------
module tlrd_norm_cell
    import tlrd_pkg::*;
#(
    parameter int LANES = 4,
    parameter int W     = 78,
    parameter int SH    = 64,
    parameter int SW    = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [LANES-1:0][W-1:0]  in_lane,
    input  logic [SW-1:0]            in_side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LANES-1:0][W-1:0]  out_lane,
    output logic [SW-1:0]            out_side
);

    logic                    valid_reg;
    logic [LANES-1:0][W-1:0] lane_reg, lane_next;
    logic [SW-1:0]           side_reg;
    logic                    hit;

    // common shift decided on the or of all magnitudes
    assign hit = (in_lane[0][W-1 -: SH] == '0);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            lane_next[l] = hit ? (in_lane[l] << SH) : in_lane[l];
    end

    assign in_ready = !valid_reg || out_ready;

    // beat occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            lane_reg <= lane_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/core/tlrd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tlrd_sqrt_cell
// One digit-by-digit integer square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module tlrd_sqrt_cell
    import tlrd_pkg::*;
#(
    parameter int SW = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SQREM_W-1:0] in_rem,
    input  logic [ROOT_W-1:0]  in_root,
    input  logic [SUM_W-1:0]   in_rad,
    input  logic [SW-1:0]      in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SQREM_W-1:0] out_rem,
    output logic [ROOT_W-1:0]  out_root,
    output logic [SUM_W-1:0]   out_rad,
    output logic [SW-1:0]      out_side
);

    logic               valid_reg;
    logic [SQREM_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SUM_W-1:0]   rad_reg, rad_next;
    logic [SW-1:0]      side_reg;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        logic [SQREM_W+1:0] t;
        logic [SQREM_W+1:0] trial;
        logic               ge;
        t         = {in_rem, in_rad[SUM_W-1 -: 2]};
        trial     = (SQREM_W + 2)'({in_root, 2'b01});
        ge        = (t >= trial);
        rem_next  = ge ? SQREM_W'(t - trial) : t[SQREM_W-1:0];
        root_next = {in_root[ROOT_W-2:0], ge};
        rad_next  = {in_rad[SUM_W-3:0], 2'b00};
    end

    assign in_ready = !valid_reg || out_ready;

    // beat occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel/lens sample beats into the thin-lens ray direction block with
// random gaps and output stalls, predicts each unit direction in a local
// fixed-point model or takes a typed-in result, and compares every returned
// beat in full. Runs through several camera settings, extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import tlrd_pkg::*;

    localparam int  LATENCY     = 92;
    localparam int  WATCHDOG    = 20000;
    localparam int  RANDOM_N    = 1600;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    thin_lens_ray_direction u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // camera settings mirrored from the register writes
    logic [31:0] cam_focal;
    logic [31:0] cam_view;
    logic [47:0] cam_u;
    logic [47:0] cam_v;
    logic [47:0] cam_w;

    out_item_t   dir_queue[$];
    int          mismatches;
    int          idle_cycles;
    bit          quiet_phase;
    bit          timed_out;

    // table of directed rows; has_dir marks rows with a typed-in result
    typedef struct {
        in_item_t  smp;
        bit        has_dir;
        out_item_t dir;
    } dir_row_t;
    dir_row_t    directed[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // focal scaling of one pixel coordinate, saturating
    function automatic logic signed [63:0] focal_point(input logic signed [31:0] pix,
                                                       inout bit sat);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = (pix < 0) ? 64'(-64'(pix)) : 64'(pix);
        if (mag == 0) return 0;
        if (cam_view == 0)
        begin
            sat = 1'b1;
            return (pix < 0) ? 64'(Q16_MIN) : 64'(Q16_MAX);
        end
        quo = (mag * 64'(cam_focal)) / 64'(cam_view);
        if (pix < 0)
        begin
            if (quo > 64'h8000_0000)
            begin
                sat = 1'b1;
                return 64'(Q16_MIN);
            end
            return -$signed(quo);
        end
        if (quo > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return 64'(Q16_MAX);
        end
        return $signed(quo);
    endfunction

    function automatic logic signed [63:0] clamp_q16(input logic signed [63:0] v,
                                                     inout bit sat);
        if (v > 64'(Q16_MAX))
        begin
            sat = 1'b1;
            return 64'(Q16_MAX);
        end
        if (v < 64'(Q16_MIN))
        begin
            sat = 1'b1;
            return 64'(Q16_MIN);
        end
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit ray direction for one sample under the current camera
    function automatic out_item_t predict_dir(input in_item_t smp);
        out_item_t   r;
        bit          sat;
        logic signed [63:0] dx, dy;
        logic signed [63:0] c[3];
        logic [63:0] mag[3];
        logic [63:0] maxm, sum, len, q;
        sat = 1'b0;
        maxm = 0;
        dx = clamp_q16(focal_point(smp.pixel_x, sat) - 64'(smp.lens_x), sat);
        dy = clamp_q16(focal_point(smp.pixel_y, sat) - 64'(smp.lens_y), sat);
        for (int k = 0; k < 3; k++)
        begin
            c[k] = dx * 64'($signed(cam_u[16*k +: 16]))
                 + dy * 64'($signed(cam_v[16*k +: 16]))
                 - $signed(64'(cam_focal)) * 64'($signed(cam_w[16*k +: 16]));
            mag[k] = (c[k] < 0) ? 64'(-c[k]) : 64'(c[k]);
            if (mag[k] > maxm) maxm = mag[k];
        end
        r = '0;
        r.saturated = sat;
        if (maxm == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        while (maxm >= (64'd1 << 30))
        begin
            maxm >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        while (maxm < (64'd1 << 29))
        begin
            maxm <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            q = (mag[k] * 64'd16384 + (len >> 1)) / len;
            if (q > 64'd16384) q = 64'd16384;
            if (c[k] < 0) q = -q;
            case (k)
                0: r.dir_x = q[15:0];
                1: r.dir_y = q[15:0];
                default: r.dir_z = q[15:0];
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_sample();
        in_item_t s;
        s.pixel_x = rand_q16();
        s.pixel_y = rand_q16();
        s.lens_x  = rand_q16();
        s.lens_y  = rand_q16();
        return s;
    endfunction

    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(0, 99) < 20);
    endfunction

    // one register write beat, only while the pipe is empty
    task automatic write_reg(input cfg_index_t idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FOCAL_DIST: cam_focal = val[31:0];
            REG_VIEW_DIST:  cam_view  = val[31:0];
            REG_BASIS_U:    cam_u     = val;
            REG_BASIS_V:    cam_v     = val;
            REG_BASIS_W:    cam_w     = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // send one sample beat and queue its expected direction
    task automatic send_sample(input in_item_t smp, input bit typed,
                               input out_item_t typed_dir);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= smp;
        do @(posedge clk); while (!in_ready);
        dir_queue.push_back(typed ? typed_dir : predict_dir(smp));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (dir_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic random_camera();
        write_reg(REG_FOCAL_DIST, ($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF
                                  : 48'($urandom_range(1, 32'h0008_0000)));
        write_reg(REG_VIEW_DIST, ($urandom_range(0, 5) == 0) ? 48'd0
                                 : 48'($urandom_range(1, 32'h0008_0000)));
        write_reg(REG_BASIS_U, {rand_comp(), rand_comp(), rand_comp()});
        write_reg(REG_BASIS_V, {rand_comp(), rand_comp(), rand_comp()});
        write_reg(REG_BASIS_W, {rand_comp(), rand_comp(), rand_comp()});
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (dir_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected direction beat %p", out_data);
                end
                else
                begin
                    out_item_t want;
                    want = dir_queue.pop_front();
                    if (out_data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("direction mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG && !timed_out)
            begin
                timed_out = 1'b1;
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // output stalls
    always @(negedge clk)
        out_ready <= !idle_now();

    task automatic add_row(input in_item_t s, input bit typed, input out_item_t d);
        dir_row_t row;
        row.smp = s;
        row.has_dir = typed;
        row.dir = d;
        directed.push_back(row);
    endtask

    initial
    begin
        in_item_t  s;
        out_item_t d;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        timed_out = 1'b0;
        cam_focal = FOCAL_RESET;
        cam_view = VIEW_RESET;
        cam_u = BASIS_U_RESET;
        cam_v = BASIS_V_RESET;
        cam_w = BASIS_W_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // after reset: straight down z
        s = '0;
        d = '0; d.dir_z = -16'sd16384;
        add_row(s, 1'b1, d);
        // extremes of pixel and lens
        s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
        add_row(s, 1'b0, d);
        s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        add_row(s, 1'b0, d);
        s = '{32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000};
        add_row(s, 1'b0, d);
        s = '{32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_0001, 32'shFFFF_FFFF};
        add_row(s, 1'b0, d);
        foreach (directed[i]) send_sample(directed[i].smp, directed[i].has_dir, directed[i].dir);
        drain();

        // zero w and zero pixel offset gives a zero-length vector
        write_reg(REG_BASIS_W, 48'd0);
        s = '{32'sh0002_0000, 32'shFFFE_0000, 32'sh0002_0000, 32'shFFFE_0000};
        d = '0; d.zero_length = 1'b1;
        send_sample(s, 1'b1, d);
        drain();
        // zero-length after clamping still reports saturation
        write_reg(REG_BASIS_U, 48'd0);
        write_reg(REG_BASIS_V, 48'd0);
        s = '{32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh0};
        d = '0; d.zero_length = 1'b1; d.saturated = 1'b1;
        send_sample(s, 1'b1, d);
        drain();

        // zero view distance and largest focal distance
        write_reg(REG_BASIS_U, {16'h8000, 16'h7FFF, 16'hC000});
        write_reg(REG_BASIS_V, {16'h7FFF, 16'h8000, 16'h4000});
        write_reg(REG_BASIS_W, {16'h8000, 16'h8000, 16'h7FFF});
        write_reg(REG_VIEW_DIST, 48'd0);
        write_reg(REG_FOCAL_DIST, 48'hFFFF_FFFF);
        send_sample('{32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0}, 1'b0, d);
        send_sample('{32'sh8000_0000, 32'shFFFF_0000, 32'sh1, 32'sh0}, 1'b0, d);
        send_sample('{32'sh0, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b0, d);
        drain();
        write_reg(REG_VIEW_DIST, 48'hFFFF_FFFF);
        write_reg(REG_FOCAL_DIST, 48'd1);
        send_sample('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0}, 1'b0, d);
        drain();
        // out-of-range index is ignored
        write_reg(cfg_index_t'(3'd7), 48'hFFFF_FFFF_FFFF);
        send_sample('{32'sh0003_0000, 32'shFFFD_0000, 32'sh1234, 32'shFFFF_1234}, 1'b0, d);
        drain();

        // random phases under random cameras
        for (int ph = 0; ph < 8; ph++)
        begin
            random_camera();
            quiet_phase = (ph == 3);
            for (int n = 0; n < RANDOM_N / 8; n++)
                send_sample(rand_sample(), 1'b0, d);
            quiet_phase = 1'b0;
            drain();
        end

        if (mismatches == 0 && dir_queue.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/tlrd_pkg.sv
rtl/core/tlrd_div_cell.sv
rtl/core/tlrd_norm_cell.sv
rtl/core/tlrd_sqrt_cell.sv
rtl/core/thin_lens_ray_direction.sv
dv/testbench.sv
